>>> rtl/bscnn_pkg.sv
`default_nettype none

package bscnn_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] RST_SOURCE_ROWS = 13'd1024;
    localparam logic [CFG_W-1:0] RST_SOURCE_COLS = 13'd1224;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_ROWS = 1'b0,
        REG_SOURCE_COLS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } sel_t;

endpackage

`default_nettype wire

>>> rtl/bscnn_select.sv
`default_nettype none

module bscnn_select
    import bscnn_pkg::*;
#(
    parameter int OUT_HEIGHT      = 640,
    parameter int OUT_WIDTH       = 640,
    parameter int MAX_SOURCE_SIDE = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             frame_start,
    input  wire logic [CFG_W-1:0] source_rows,
    input  wire logic [CFG_W-1:0] source_cols,
    output sel_t                  sel
);

    localparam int MAXOUT = (OUT_HEIGHT > OUT_WIDTH) ? OUT_HEIGHT : OUT_WIDTH;
    localparam int RW     = $clog2(MAX_SOURCE_SIDE + 1);
    localparam int XW     = (RW > CFG_W) ? RW : CFG_W;
    localparam int OHW    = $clog2(OUT_HEIGHT + 1);
    localparam int OWW    = $clog2(OUT_WIDTH + 1);
    localparam int SW     = $clog2(MAXOUT * (MAX_SOURCE_SIDE + 1) + 1);

    logic [RW-1:0]  src_row_reg, src_row_next;
    logic [RW-1:0]  src_col_reg, src_col_next;
    logic [RW-1:0]  crop_side_reg, crop_side_next;
    logic [RW-1:0]  crop_first_row_reg, crop_first_row_next;
    logic [RW-1:0]  frame_cols_reg, frame_cols_next;
    logic [OHW-1:0] next_out_row_reg, next_out_row_next;
    logic [OWW-1:0] next_out_col_reg, next_out_col_next;
    logic [SW-1:0]  out_row_scaled_reg, out_row_scaled_next;
    logic [SW-1:0]  out_col_scaled_reg, out_col_scaled_next;
    logic [SW-1:0]  src_row_scaled_reg, src_row_scaled_next;
    logic [SW-1:0]  src_col_scaled_reg, src_col_scaled_next;

    logic [XW-1:0]  rows_ext, cols_ext;
    logic [RW-1:0]  rows_clamp, cols_clamp, side_fresh;

    logic [RW-1:0]  cur_src_row, cur_src_col, cur_side, cur_first, cur_cols;
    logic [OHW-1:0] cur_out_row;
    logic [OWW-1:0] cur_out_col;
    logic [SW-1:0]  cur_out_row_scaled, cur_out_col_scaled;
    logic [SW-1:0]  cur_src_row_scaled, cur_src_col_scaled;

    logic           ignore, in_crop_rows, row_sel, col_sel, emit, row_end, end_of_row;

    always_comb
    begin
        rows_ext = XW'(source_rows);
        cols_ext = XW'(source_cols);
        if (rows_ext > XW'(MAX_SOURCE_SIDE))
            rows_clamp = RW'(MAX_SOURCE_SIDE);
        else if (rows_ext < XW'(MAXOUT))
            rows_clamp = RW'(MAXOUT);
        else
            rows_clamp = RW'(rows_ext);
        if (cols_ext > XW'(MAX_SOURCE_SIDE))
            cols_clamp = RW'(MAX_SOURCE_SIDE);
        else if (cols_ext < XW'(MAXOUT))
            cols_clamp = RW'(MAXOUT);
        else
            cols_clamp = RW'(cols_ext);
        side_fresh = (rows_clamp < cols_clamp) ? rows_clamp : cols_clamp;
    end

    always_comb
    begin
        if (frame_start)
        begin
            cur_side           = side_fresh;
            cur_first          = rows_clamp - side_fresh;
            cur_cols           = cols_clamp;
            cur_src_row        = '0;
            cur_src_col        = '0;
            cur_out_row        = '0;
            cur_out_col        = '0;
            cur_out_row_scaled = '0;
            cur_out_col_scaled = '0;
            cur_src_row_scaled = '0;
            cur_src_col_scaled = '0;
        end
        else
        begin
            cur_side           = crop_side_reg;
            cur_first          = crop_first_row_reg;
            cur_cols           = frame_cols_reg;
            cur_src_row        = src_row_reg;
            cur_src_col        = src_col_reg;
            cur_out_row        = next_out_row_reg;
            cur_out_col        = next_out_col_reg;
            cur_out_row_scaled = out_row_scaled_reg;
            cur_out_col_scaled = out_col_scaled_reg;
            cur_src_row_scaled = src_row_scaled_reg;
            cur_src_col_scaled = src_col_scaled_reg;
        end
    end

    always_comb
    begin
        ignore = (cur_side == '0)
              || ({1'b0, cur_src_row} >= ({1'b0, cur_first} + {1'b0, cur_side}));
        in_crop_rows = cur_src_row >= cur_first;
        row_sel = in_crop_rows && (cur_out_row < OHW'(OUT_HEIGHT))
               && (cur_out_row_scaled < cur_src_row_scaled + SW'(OUT_HEIGHT));
        col_sel = (cur_src_col < cur_side) && (cur_out_col < OWW'(OUT_WIDTH))
               && (cur_out_col_scaled < cur_src_col_scaled + SW'(OUT_WIDTH));
        emit = !ignore && row_sel && col_sel;
        row_end = cur_out_col == OWW'(OUT_WIDTH - 1);
        end_of_row = ({1'b0, cur_src_col} + (RW+1)'(1)) >= {1'b0, cur_cols};

        sel.emit      = emit;
        sel.row_end   = row_end;
        sel.frame_end = row_end && (cur_out_row == OHW'(OUT_HEIGHT - 1));
    end

    always_comb
    begin
        crop_side_next      = cur_side;
        crop_first_row_next = cur_first;
        frame_cols_next     = cur_cols;
        src_row_next        = cur_src_row;
        src_col_next        = cur_src_col;
        next_out_row_next   = cur_out_row;
        next_out_col_next   = cur_out_col;
        out_row_scaled_next = cur_out_row_scaled;
        out_col_scaled_next = cur_out_col_scaled;
        src_row_scaled_next = cur_src_row_scaled;
        src_col_scaled_next = cur_src_col_scaled;
        if (!ignore)
        begin
            if (emit)
            begin
                next_out_col_next   = cur_out_col + OWW'(1);
                out_col_scaled_next = cur_out_col_scaled + SW'(cur_side);
            end
            if (end_of_row)
            begin
                src_col_next        = '0;
                src_col_scaled_next = '0;
                next_out_col_next   = '0;
                out_col_scaled_next = '0;
                if (row_sel)
                begin
                    next_out_row_next   = cur_out_row + OHW'(1);
                    out_row_scaled_next = cur_out_row_scaled + SW'(cur_side);
                end
                if (in_crop_rows)
                    src_row_scaled_next = cur_src_row_scaled + SW'(OUT_HEIGHT);
                src_row_next = cur_src_row + RW'(1);
            end
            else
            begin
                src_col_next        = cur_src_col + RW'(1);
                src_col_scaled_next = cur_src_col_scaled + SW'(OUT_WIDTH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_row_reg        <= '0;
            src_col_reg        <= '0;
            crop_side_reg      <= '0;
            crop_first_row_reg <= '0;
            frame_cols_reg     <= '0;
            next_out_row_reg   <= '0;
            next_out_col_reg   <= '0;
            out_row_scaled_reg <= '0;
            out_col_scaled_reg <= '0;
            src_row_scaled_reg <= '0;
            src_col_scaled_reg <= '0;
        end
        else if (step)
        begin
            src_row_reg        <= src_row_next;
            src_col_reg        <= src_col_next;
            crop_side_reg      <= crop_side_next;
            crop_first_row_reg <= crop_first_row_next;
            frame_cols_reg     <= frame_cols_next;
            next_out_row_reg   <= next_out_row_next;
            next_out_col_reg   <= next_out_col_next;
            out_row_scaled_reg <= out_row_scaled_next;
            out_col_scaled_reg <= out_col_scaled_next;
            src_row_scaled_reg <= src_row_scaled_next;
            src_col_scaled_reg <= src_col_scaled_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bottom_square_crop_nn_scaler_core.sv
// Bottom-anchored square crop and nearest-neighbor downscaler.
// Slave stream: one source BGR pixel per item, raster order; s_tuser marks
// the first pixel of a frame and restarts all counters. Master stream: the
// selected pixels of an OUT_HEIGHT x OUT_WIDTH image; m_tlast marks the last
// pixel of an output row, m_tuser the last pixel of the frame.
// Config port: cfg_we writes cfg_data into source_rows (index 0) or
// source_cols (index 1); the sizes take effect at the next frame start and
// are saturated to [max(OUT_HEIGHT, OUT_WIDTH), MAX_SOURCE_SIDE].
// An accepted pixel that is selected is registered and shows on the master
// side in the next cycle. Throughput: one item per cycle, set by the single result
// register; s_tready stays high while that register is empty or being taken.
// When the receiver stalls with a result held, s_tready drops until it is
// taken. Each input item gives zero or one output item.
// Reset: sizes go to 1024 x 1224, counters clear, and nothing is produced
// until the first frame start.

`default_nettype none

module bottom_square_crop_nn_scaler_core
    import bscnn_pkg::*;
#(
    parameter int OUT_HEIGHT      = 640,
    parameter int OUT_WIDTH       = 640,
    parameter int MAX_SOURCE_SIDE = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [3*PIX_W-1:0]   s_tdata,  // pixel_blue, pixel_green, pixel_red
    input  wire logic                 s_tuser,  // frame_start
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [3*PIX_W-1:0]   m_tdata,  // out_blue, out_green, out_red
    output      logic                 m_tlast,  // row_end
    output      logic                 m_tuser,  // frame_end
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]   source_rows_reg, source_cols_reg;
    logic               m_valid_reg, m_valid_next;
    logic [3*PIX_W-1:0] m_data_reg;
    logic               m_last_reg, m_user_reg;
    logic               accept;
    sel_t               sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_rows_reg <= RST_SOURCE_ROWS;
            source_cols_reg <= RST_SOURCE_COLS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_ROWS: source_rows_reg <= cfg_data;
                REG_SOURCE_COLS: source_cols_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bscnn_select #(
        .OUT_HEIGHT      (OUT_HEIGHT),
        .OUT_WIDTH       (OUT_WIDTH),
        .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE)
    ) u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .frame_start (s_tuser),
        .source_rows (source_rows_reg),
        .source_cols (source_cols_reg),
        .sel         (sel)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (accept)
            m_valid_next = sel.emit;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && sel.emit)
        begin
            m_data_reg <= s_tdata;
            m_last_reg <= sel.row_end;
            m_user_reg <= sel.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bscnn_pkg::*;

    localparam int OUT_H      = 640;
    localparam int OUT_W      = 640;
    localparam int MAX_SIDE   = 4096;
    localparam int MIN_SIDE   = (OUT_H > OUT_W) ? OUT_H : OUT_W;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_ITEMS = 250;
    localparam int TAIL_ROWS  = 640;
    localparam int TAIL_COLS  = 700;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } bgr_t;

    typedef struct packed {
        logic frame_end;
        logic row_end;
        bgr_t px;
    } scaled_px_t;

    typedef struct {
        logic       to_reg;
        cfg_reg_t   which;
        logic [CFG_W-1:0] value;
        bgr_t       px;
        logic       fs;
        logic       typed;
        logic       emit;
        scaled_px_t res;
    } bench_step_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [3*PIX_W-1:0] s_tdata = '0;  // pixel_blue, pixel_green, pixel_red
    logic             s_tuser = 1'b0;  // frame_start
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [3*PIX_W-1:0] m_tdata;       // out_blue, out_green, out_red
    logic             m_tlast;         // row_end
    logic             m_tuser;         // frame_end
    logic             cfg_we = 1'b0;
    cfg_reg_t         cfg_index = REG_SOURCE_ROWS;
    logic [CFG_W-1:0] cfg_data = '0;

    bottom_square_crop_nn_scaler_core #(
        .OUT_HEIGHT      (OUT_H),
        .OUT_WIDTH       (OUT_W),
        .MAX_SOURCE_SIDE (MAX_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scaler state as seen by the bench
    logic [CFG_W-1:0] reg_rows = RST_SOURCE_ROWS;
    logic [CFG_W-1:0] reg_cols = RST_SOURCE_COLS;
    logic [13:0] cur_row = '0;
    logic [13:0] cur_col = '0;
    logic [13:0] side_len = '0;
    logic [13:0] top_row = '0;
    logic [13:0] line_len = '0;
    logic [10:0] out_y = '0;
    logic [10:0] out_x = '0;
    logic [23:0] out_y_acc = '0;
    logic [23:0] out_x_acc = '0;
    logic [23:0] in_y_acc = '0;
    logic [23:0] in_x_acc = '0;

    scaled_px_t  pending_px_q[$];
    bench_step_t directed_steps[$];
    int          fault_count = 0;
    int          sent_items = 0;
    logic        idle_en = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [13:0] saturate_size(input logic [CFG_W-1:0] v);
        if (v > MAX_SIDE)
            return 14'(MAX_SIDE);
        if (v < MIN_SIDE)
            return 14'(MIN_SIDE);
        return 14'(v);
    endfunction

    function automatic void scale_pixel(input bgr_t px, input logic fs,
                                        output logic hit, output scaled_px_t res);
        logic [13:0] r;
        logic [13:0] c;
        logic row_pick;
        logic col_pick;
        hit = 1'b0;
        res = '0;
        if (fs)
        begin
            r = saturate_size(reg_rows);
            c = saturate_size(reg_cols);
            side_len = (r < c) ? r : c;
            top_row = r - side_len;
            line_len = c;
            cur_row = '0;
            cur_col = '0;
            out_y = '0;
            out_x = '0;
            out_y_acc = '0;
            out_x_acc = '0;
            in_y_acc = '0;
            in_x_acc = '0;
        end
        // drop items with no frame or past the last cropped row
        if (side_len == 0 || cur_row >= top_row + side_len)
            return;
        row_pick = cur_row >= top_row && out_y < OUT_H && out_y_acc < in_y_acc + OUT_H;
        col_pick = cur_col < side_len && out_x < OUT_W && out_x_acc < in_x_acc + OUT_W;
        if (row_pick && col_pick)
        begin
            hit = 1'b1;
            res.px = px;
            res.row_end = (out_x == OUT_W - 1);
            res.frame_end = res.row_end && (out_y == OUT_H - 1);
            out_x = out_x + 11'd1;
            out_x_acc = out_x_acc + side_len;
        end
        if (cur_col + 1 >= line_len)
        begin
            cur_col = '0;
            in_x_acc = '0;
            out_x = '0;
            out_x_acc = '0;
            if (row_pick)
            begin
                out_y = out_y + 11'd1;
                out_y_acc = out_y_acc + side_len;
            end
            if (cur_row >= top_row)
                in_y_acc = in_y_acc + 24'(OUT_H);
            cur_row = cur_row + 14'd1;
        end
        else
        begin
            cur_col = cur_col + 14'd1;
            in_x_acc = in_x_acc + 24'(OUT_W);
        end
    endfunction

    function automatic bench_step_t blank_step();
        bench_step_t s;
        s.to_reg = 1'b0;
        s.which = REG_SOURCE_ROWS;
        s.value = '0;
        s.px = '0;
        s.fs = 1'b0;
        s.typed = 1'b0;
        s.emit = 1'b0;
        s.res = '0;
        return s;
    endfunction

    function automatic bench_step_t size_step(input cfg_reg_t which,
                                              input logic [CFG_W-1:0] value);
        bench_step_t s;
        s = blank_step();
        s.to_reg = 1'b1;
        s.which = which;
        s.value = value;
        return s;
    endfunction

    function automatic bench_step_t pixel_step(input bgr_t px, input logic fs);
        bench_step_t s;
        s = blank_step();
        s.px = px;
        s.fs = fs;
        return s;
    endfunction

    function automatic bench_step_t known_step(input bgr_t px, input logic fs,
                                               input logic emit, input logic re,
                                               input logic fe);
        bench_step_t s;
        s = pixel_step(px, fs);
        s.typed = 1'b1;
        s.emit = emit;
        s.res.px = px;
        s.res.row_end = re;
        s.res.frame_end = fe;
        return s;
    endfunction

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    task automatic write_size(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_px_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == REG_SOURCE_ROWS)
            reg_rows = value;
        else
            reg_cols = value;
    endtask

    task automatic send_pixel(input bgr_t px, input logic fs, input logic typed,
                              input logic typed_emit, input scaled_px_t typed_res);
        logic hit;
        scaled_px_t res;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        s_tuser <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scale_pixel(px, fs, hit, res);
        if (typed)
        begin
            hit = typed_emit;
            res = typed_res;
        end
        if (hit)
            pending_px_q.push_back(res);
        sent_items++;
    endtask

    // output side: check items, stall in bursts
    initial
    begin : result_side
        int stall_left;
        scaled_px_t want;
        bgr_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_px_q.size() == 0)
                begin
                    log_fault($sformatf("unexpected item: px=%06h row_end=%b frame_end=%b",
                                        m_tdata, m_tlast, m_tuser));
                end
                else
                begin
                    want = pending_px_q.pop_front();
                    if (got.blue !== want.px.blue || got.green !== want.px.green ||
                        got.red !== want.px.red || m_tlast !== want.row_end ||
                        m_tuser !== want.frame_end)
                    begin
                        log_fault($sformatf(
                    "mismatch: exp px=%06h last=%b user=%b, got px=%06h last=%b user=%b",
                            want.px, want.row_end, want.frame_end, m_tdata, m_tlast, m_tuser));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("bottom_square_crop_nn_scaler_core test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        int burst_len;
        bgr_t px;
        logic fs;

        directed_steps = '{
            known_step(24'h000000, 1'b0, 1'b0, 1'b0, 1'b0),
            known_step(24'hffffff, 1'b0, 1'b0, 1'b0, 1'b0),
            size_step(REG_SOURCE_ROWS, 13'd0),
            size_step(REG_SOURCE_COLS, 13'd8191),
            known_step(24'hffffff, 1'b1, 1'b1, 1'b0, 1'b0),
            known_step(24'h000000, 1'b0, 1'b1, 1'b0, 1'b0),
            pixel_step(24'h5aa53c, 1'b0),
            size_step(REG_SOURCE_ROWS, 13'd8191),
            size_step(REG_SOURCE_COLS, 13'd639),
            pixel_step(24'h123456, 1'b0),
            known_step(24'habcdef, 1'b1, 1'b0, 1'b0, 1'b0),
            pixel_step(24'h654321, 1'b0),
            size_step(REG_SOURCE_ROWS, 13'd4096),
            size_step(REG_SOURCE_COLS, 13'd4096),
            known_step(24'h00ff00, 1'b1, 1'b1, 1'b0, 1'b0),
            pixel_step(24'hff00ff, 1'b0),
            pixel_step(24'h0f0f0f, 1'b0),
            known_step(24'hf0f0f0, 1'b1, 1'b1, 1'b0, 1'b0),
            size_step(REG_SOURCE_ROWS, 13'd4097),
            size_step(REG_SOURCE_COLS, 13'd700),
            known_step(24'h808080, 1'b1, 1'b0, 1'b0, 1'b0),
            pixel_step(24'h7f7f7f, 1'b0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].to_reg)
                write_size(directed_steps[i].which, directed_steps[i].value);
            else
                send_pixel(directed_steps[i].px, directed_steps[i].fs,
                           directed_steps[i].typed, directed_steps[i].emit,
                           directed_steps[i].res);
        end

        // short frames, mostly near the smallest square, some with odd sizes
        while (sent_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                rows = 13'($urandom_range(0, 8191));
                cols = 13'($urandom_range(0, 8191));
            end
            else
            begin
                cols = 13'($urandom_range(640, 760));
                rows = 13'($urandom_range(640, cols + 3));
            end
            if ($urandom_range(0, 3) != 0)
                write_size(REG_SOURCE_ROWS, rows);
            write_size(REG_SOURCE_COLS, cols);
            burst_len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 150)
                                                    : $urandom_range(620, 1500);
            if (burst_len > RANDOM_ITEMS - sent_items)
                burst_len = RANDOM_ITEMS - sent_items;
            for (int n = 0; n < burst_len; n++)
            begin
                px = 24'($urandom);
                fs = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 299) == 0);
                send_pixel(px, fs, 1'b0, 1'b0, '0);
            end
        end

        // one frame start, then back to back items with no idling on either side
        write_size(REG_SOURCE_ROWS, 13'(TAIL_ROWS));
        write_size(REG_SOURCE_COLS, 13'(TAIL_COLS));
        idle_en = 1'b0;
        for (int n = 0; n < TAIL_ITEMS; n++)
        begin
            px = 24'($urandom);
            send_pixel(px, n == 0, 1'b0, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_px_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fault_count == 0)
            $display("bottom_square_crop_nn_scaler_core test passed");
        else
            $display("bottom_square_crop_nn_scaler_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
